// ===== sv/knn_rd_pkg.sv =====
package knn_rd_pkg;

   localparam int MaxSamplesDef = 1024;
   localparam int MaxNewDef     = 256;
   localparam int NeighboursDef = 8;

   localparam logic [15:0] ONE_Q15     = 16'h8000;
   localparam logic [31:0] RATIO_UNITY = 32'h0001_0000;
   localparam logic [31:0] RATIO_MAX   = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_LOAD_PROB   = 3'd0,
      OP_LOAD_NBR    = 3'd1,
      OP_LOAD_WEIGHT = 3'd2,
      OP_RUN         = 3'd3,
      OP_READ        = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_SMOOTHING = 2'd0,
      CSR_ITER      = 2'd1,
      CSR_SAMPLES   = 2'd2,
      CSR_NEW       = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      CS_IDLE, CS_READ, CS_J, CS_P, CS_T, CS_M, CS_ACC,
      CS_DIV, CS_DWAIT, CS_BR, CS_BM, CS_BW, CS_FIN
   } core_state_type;

   typedef struct packed {
      logic [15:0] smoothing;
      logic [15:0] iteration_count;
      logic [10:0] sample_count;
      logic [8:0]  new_count;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] prob_first;
      logic [15:0] prob_second;
   } rsp_type;

endpackage

// ===== sv/knn_rd_div.sv =====
module knn_rd_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 38
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [31:0]      quotient
);
   import knn_rd_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [31:0]      low_ff, low_in;
   logic [31:0]      q_ff, q_in;
   logic [DEN_W:0]   sh, diff;
   logic             ge;

   always_comb begin
      sh      = {rem_ff, low_ff[31]};
      diff    = sh - {1'b0, den_ff};
      ge      = sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         den_in = den;
         if (DEN_W'(num[NUM_W-1:16]) >= den) begin
            q_in    = RATIO_MAX;
            done_in = 1'b1;
         end else begin
            rem_in  = DEN_W'(num[NUM_W-1:16]);
            low_in  = {num[15:0], 16'h0000};
            cnt_in  = 5'd0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
         q_in   = {q_ff[30:0], ge};
         low_in = {low_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sv/knn_rd_core.sv =====
module knn_rd_core #(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_NEW     = 256,
   parameter int NEIGHBOURS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  knn_rd_pkg::cfg_type cfg,
   input  logic                accept,
   input  logic [2:0]          op,
   input  logic [9:0]          row,
   input  logic [2:0]          slot,
   input  logic [15:0]         value_a,
   input  logic [15:0]         value_b,
   output logic                idle,
   output logic                res_valid,
   output knn_rd_pkg::rsp_type res
);
   import knn_rd_pkg::*;

   localparam int SW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NW     = (MAX_NEW > 1) ? $clog2(MAX_NEW) : 1;
   localparam int NCW    = $clog2(MAX_NEW + 1);
   localparam int TD     = MAX_NEW * NEIGHBOURS;
   localparam int TW     = (TD > 1) ? $clog2(TD) : 1;
   localparam int KW     = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
   localparam int MIN_W  = 32 + $clog2(NEIGHBOURS);
   localparam int TOT_W  = 49 + $clog2(NEIGHBOURS);
   localparam int NUM_W  = MIN_W + 1;
   localparam int DSUM_W = TOT_W + 1;
   localparam int DEN_W  = DSUM_W - 15;

   logic [15:0] p1_mem_ff [MAX_SAMPLES];
   logic [15:0] p2_mem_ff [MAX_SAMPLES];
   logic [SW-1:0] nbr_mem_ff [TD];
   logic [15:0] wt_mem_ff [TD];
   logic [32:0] rat_mem_ff [MAX_NEW];

   logic [15:0]   p1_rd_ff, p2_rd_ff, wt_rd_ff;
   logic [SW-1:0] nbr_rd_ff;
   logic [32:0]   rat_rd_ff;

   logic [SW-1:0] p_raddr, p_waddr;
   logic          p_we;
   logic [15:0]   p_wd1, p_wd2;
   logic [TW-1:0] t_raddr, t_waddr;
   logic          t_we_n, t_we_w;
   logic [NW-1:0] r_raddr;
   logic          r_we;
   logic [32:0]   r_wd;

   core_state_type state_ff, state_in;
   logic [SW-1:0]  first_ff, first_in;
   logic [NCW-1:0] nc_ff, nc_in;
   logic [NW-1:0]  j_ff, j_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [TW-1:0]  ta_ff, ta_in;
   logic [15:0]    it_ff, it_in;
   logic           zero_ff, zero_in;
   logic [15:0]    pj1_ff, pj1_in, pj2_ff, pj2_in, w_ff, w_in;
   logic [31:0]    m1_ff, m1_in, m2_ff, m2_in, mw_ff, mw_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [MIN_W-1:0] min_ff, min_in;
   logic [47:0]    prod_ff, prod_in;
   logic           hold_ff, hold_in;

   logic [31:0]    row_ext, taddr32, sc32, nc32, pnew32;
   logic           prow_ok, tab_ok, va_ok, last_j;
   logic [32:0]    msum;
   logic [48:0]    wprod;
   logic [NUM_W-1:0]  num;
   logic [DSUM_W-1:0] dsum;
   logic [DEN_W-1:0]  den;
   logic           div_start, div_done;
   logic [31:0]    div_q;
   logic [SW-1:0]  pj_addr;

   knn_rd_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num),
      .den      (den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (p_we) begin
         p1_mem_ff[p_waddr] <= p_wd1;
         p2_mem_ff[p_waddr] <= p_wd2;
      end
      p1_rd_ff <= p1_mem_ff[p_raddr];
      p2_rd_ff <= p2_mem_ff[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we_n) nbr_mem_ff[t_waddr] <= SW'(32'(value_a) - 32'd1);
      if (t_we_w) wt_mem_ff[t_waddr] <= value_a;
      nbr_rd_ff <= nbr_mem_ff[t_raddr];
      wt_rd_ff  <= wt_mem_ff[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) rat_mem_ff[j_ff] <= r_wd;
      rat_rd_ff <= rat_mem_ff[r_raddr];
   end

   always_comb begin
      row_ext = 32'(row);
      prow_ok = row_ext < 32'(MAX_SAMPLES);
      tab_ok  = (row_ext < 32'(MAX_NEW)) && (32'(slot) < 32'(NEIGHBOURS));
      va_ok   = (value_a != 16'd0) && (32'(value_a) <= 32'(MAX_SAMPLES));
      taddr32 = row_ext * 32'(NEIGHBOURS) + 32'(slot);
      sc32    = (32'(cfg.sample_count) > 32'(MAX_SAMPLES)) ?
                32'(MAX_SAMPLES) : 32'(cfg.sample_count);
      nc32    = (32'(cfg.new_count) > 32'(MAX_NEW)) ? 32'(MAX_NEW) : 32'(cfg.new_count);
      if (nc32 > sc32) nc32 = sc32;
      last_j  = (32'(j_ff) + 32'd1) == 32'(nc_ff);
      pj_addr = first_ff + SW'(j_ff);
      msum    = {1'b0, m1_ff} + {1'b0, m2_ff};
      wprod   = 49'(w_ff) * 49'(msum);
      num     = NUM_W'({cfg.smoothing, 15'd0}) + NUM_W'(min_ff);
      dsum    = DSUM_W'({cfg.smoothing, 30'd0}) + DSUM_W'(tot_ff);
      den     = dsum[DSUM_W-1:15];
      pnew32  = 32'(prod_ff[47:16]);
      if (pnew32 > 32'(ONE_Q15)) pnew32 = 32'(ONE_Q15);
   end

   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      nc_in     = nc_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      ta_in     = ta_ff;
      it_in     = it_ff;
      zero_in   = zero_ff;
      pj1_in    = pj1_ff;
      pj2_in    = pj2_ff;
      w_in      = w_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      mw_in     = mw_ff;
      tot_in    = tot_ff;
      min_in    = min_ff;
      prod_in   = prod_ff;
      hold_in   = hold_ff;
      p_raddr   = SW'(row_ext);
      p_waddr   = SW'(row_ext);
      p_we      = 1'b0;
      p_wd1     = value_a;
      p_wd2     = value_b;
      t_raddr   = ta_ff;
      t_waddr   = TW'(taddr32);
      t_we_n    = 1'b0;
      t_we_w    = 1'b0;
      r_raddr   = j_ff;
      r_we      = 1'b0;
      r_wd      = {1'b0, div_q};
      div_start = 1'b0;
      res_valid = 1'b0;
      res       = '{status: ST_OK, prob_first: 16'd0, prob_second: 16'd0};
      unique case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               unique case (op_type'(op))
                  OP_LOAD_PROB: begin
                     res_valid = 1'b1;
                     if (prow_ok) p_we = 1'b1;
                     else res.status = ST_RANGE;
                  end
                  OP_LOAD_NBR: begin
                     res_valid = 1'b1;
                     if (tab_ok && va_ok) t_we_n = 1'b1;
                     else res.status = ST_RANGE;
                  end
                  OP_LOAD_WEIGHT: begin
                     res_valid = 1'b1;
                     if (tab_ok) t_we_w = 1'b1;
                     else res.status = ST_RANGE;
                  end
                  OP_RUN: begin
                     first_in = SW'(sc32 - nc32);
                     nc_in    = NCW'(nc32);
                     j_in     = '0;
                     k_in     = '0;
                     ta_in    = '0;
                     it_in    = 16'd0;
                     zero_in  = 1'b0;
                     if (cfg.iteration_count == 16'd0 || nc32 == 32'd0) state_in = CS_FIN;
                     else state_in = CS_J;
                  end
                  OP_READ: begin
                     if (prow_ok) begin
                        state_in = CS_READ;
                     end else begin
                        res_valid  = 1'b1;
                        res.status = ST_RANGE;
                     end
                  end
                  default: res_valid = 1'b1;
               endcase
            end
         end
         CS_READ: begin
            res_valid       = 1'b1;
            res.prob_first  = p1_rd_ff;
            res.prob_second = p2_rd_ff;
            state_in        = CS_IDLE;
         end
         CS_J: begin
            p_raddr  = pj_addr;
            state_in = CS_P;
         end
         CS_P: begin
            pj1_in   = p1_rd_ff;
            pj2_in   = p2_rd_ff;
            tot_in   = '0;
            min_in   = '0;
            k_in     = '0;
            state_in = CS_T;
         end
         CS_T: begin
            p_raddr  = nbr_rd_ff;
            w_in     = wt_rd_ff;
            state_in = CS_M;
         end
         CS_M: begin
            m1_in    = p1_rd_ff * pj1_ff;
            m2_in    = p2_rd_ff * pj2_ff;
            mw_in    = w_ff * p1_rd_ff;
            state_in = CS_ACC;
         end
         CS_ACC: begin
            tot_in  = tot_ff + TOT_W'(wprod);
            min_in  = min_ff + MIN_W'(mw_ff);
            ta_in   = ta_ff + TW'(1);
            t_raddr = ta_ff + TW'(1);
            if (32'(k_ff) == 32'(NEIGHBOURS - 1)) begin
               state_in = CS_DIV;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = CS_T;
            end
         end
         CS_DIV: begin
            if (den == '0) begin
               r_we    = 1'b1;
               r_wd    = {1'b1, RATIO_UNITY};
               zero_in = 1'b1;
               if (last_j) begin
                  j_in     = '0;
                  state_in = CS_BR;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = CS_J;
               end
            end else begin
               div_start = 1'b1;
               state_in  = CS_DWAIT;
            end
         end
         CS_DWAIT: begin
            if (div_done) begin
               r_we = 1'b1;
               if (last_j) begin
                  j_in     = '0;
                  state_in = CS_BR;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = CS_J;
               end
            end
         end
         CS_BR: begin
            p_raddr  = pj_addr;
            state_in = CS_BM;
         end
         CS_BM: begin
            prod_in  = p1_rd_ff * rat_rd_ff[31:0];
            hold_in  = rat_rd_ff[32];
            state_in = CS_BW;
         end
         CS_BW: begin
            p_waddr = pj_addr;
            p_wd1   = pnew32[15:0];
            p_wd2   = ONE_Q15 - pnew32[15:0];
            p_we    = !hold_ff;
            if (last_j) begin
               j_in  = '0;
               ta_in = '0;
               if (it_ff + 16'd1 == cfg.iteration_count) begin
                  state_in = CS_FIN;
               end else begin
                  it_in    = it_ff + 16'd1;
                  state_in = CS_J;
               end
            end else begin
               j_in     = j_ff + NW'(1);
               state_in = CS_BR;
            end
         end
         CS_FIN: begin
            res_valid  = 1'b1;
            res.status = zero_ff ? ST_ZERO_DEN : ST_OK;
            state_in   = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else state_ff <= state_in;
      first_ff <= first_in;
      nc_ff    <= nc_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      ta_ff    <= ta_in;
      it_ff    <= it_in;
      zero_ff  <= zero_in;
      pj1_ff   <= pj1_in;
      pj2_ff   <= pj2_in;
      w_ff     <= w_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      mw_ff    <= mw_in;
      tot_ff   <= tot_in;
      min_ff   <= min_in;
      prod_ff  <= prod_in;
      hold_ff  <= hold_in;
   end

   assign idle = state_ff == CS_IDLE;

endmodule

// ===== sv/knn_replicator_dynamics_top.sv =====
// Loads, unknown ops: word passes pending and output regs; in-range reads add CS_READ.
// Run: each neighbour's probabilities come through the single prob-memory read port,
//   and each nonzero-denominator row's ratio comes from the 32-step shared divider.
// One item in flight; a pending word and the output register let one more be accepted.
// Synchronous active-high reset clears control, presets cfg; memories are not cleared.
module knn_replicator_dynamics_top #(
   parameter int MAX_SAMPLES = knn_rd_pkg::MaxSamplesDef,
   parameter int MAX_NEW     = knn_rd_pkg::MaxNewDef,
   parameter int NEIGHBOURS  = knn_rd_pkg::NeighboursDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [9:0]  req_row,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_value_a,
   input  logic [15:0] req_value_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_prob_first,
   output logic [15:0] rsp_prob_second,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import knn_rd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   rsp_type pend_ff, pend_in, out_ff, out_in, res;
   logic    pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;
   logic    move, accept, core_idle, res_valid;

   knn_rd_core #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_NEW     (MAX_NEW),
      .NEIGHBOURS  (NEIGHBOURS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .op        (req_op),
      .row       (req_row),
      .slot      (req_slot),
      .value_a   (req_value_a),
      .value_b   (req_value_b),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      move      = pend_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall = !core_idle || (pend_valid_ff && !move);
      accept    = req_valid && !req_stall;

      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_SMOOTHING: cfg_in.smoothing       = csr_data;
            CSR_ITER:      cfg_in.iteration_count = csr_data;
            CSR_SAMPLES:   cfg_in.sample_count    = csr_data[10:0];
            CSR_NEW:       cfg_in.new_count       = csr_data[8:0];
            default:       cfg_in = cfg_ff;
         endcase
      end

      pend_valid_in = res_valid || (pend_valid_ff && !move);
      pend_in       = res_valid ? res : pend_ff;
      out_valid_in  = move || (out_valid_ff && rsp_stall);
      out_in        = move ? pend_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{smoothing: 16'd0, iteration_count: 16'd0,
                            sample_count: 11'd1024, new_count: 9'd0};
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_prob_first  = out_ff.prob_first;
   assign rsp_prob_second = out_ff.prob_second;

endmodule

// ===== sv/knn_rd_checker.sv =====
module knn_rd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_prob_first,
   input logic [15:0] rsp_prob_second
);
   import knn_rd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("unknown status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_prob_first == 16'd0 && rsp_prob_second == 16'd0)
      else $error("error word carries row data");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind knn_replicator_dynamics_top knn_rd_checker u_chk (.*);

// ===== verif/knn_replicator_dynamics_top_tb.sv =====
`timescale 1ns / 1ps

module knn_replicator_dynamics_top_tb;
   import knn_rd_pkg::*;

   localparam int NSAMP = 1024;
   localparam int NNEW = 256;
   localparam int NSLOT = 8;
   localparam int IDLE_LIMIT = 3000000;

   typedef struct {
      logic [2:0]  op;
      logic [9:0]  row;
      logic [2:0]  slot;
      logic [15:0] va;
      logic [15:0] vb;
   } req_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [9:0]  req_row = '0;
   logic [2:0]  req_slot = '0;
   logic [15:0] req_value_a = '0;
   logic [15:0] req_value_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_prob_first;
   logic [15:0] rsp_prob_second;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   knn_replicator_dynamics_top uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] p1_mem [NSAMP];
   logic [15:0] p2_mem [NSAMP];
   logic [9:0]  nbr_mem [NNEW*NSLOT];
   logic [15:0] wgt_mem [NNEW*NSLOT];
   bit          prob_written [NSAMP];
   bit          nbr_written [NNEW*NSLOT];
   bit          wgt_written [NNEW*NSLOT];
   int          written_rows [$];
   logic [15:0] cfg_smooth = 0;
   logic [15:0] cfg_iter = 0;
   logic [10:0] cfg_samples = 11'd1024;
   logic [8:0]  cfg_new = 0;

   req_word_t pending_words [$];
   rsp_type   expected_rows [$];
   req_word_t drive_word;
   rsp_type   head;

   bit req_taken = 1'b0;
   int burst_left = 8, gap_left = 0;
   int long_hold = 0, hold_asked = 0, hold_served = 0;
   int stall_tick = 0, stall_mode = 0;
   int idle_cycles = 0, err_count = 0;
   int words_in = 0, results_seen = 0, runs_sent = 0, zero_den_runs = 0;

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic replicate_once(input int first, input int count, output bit zero_seen);
      longint unsigned s, p1j, p2j, tot, mnr, num, den, rat, w, p1n, p2n, p;
      int n, a;
      logic [31:0] rs [NNEW];
      bit hf [NNEW];
      s = cfg_smooth;
      zero_seen = 0;
      for (int j = 0; j < count; j++) begin
         p1j = p1_mem[first+j];
         p2j = p2_mem[first+j];
         tot = 0;
         mnr = 0;
         for (int k = 0; k < NSLOT; k++) begin
            a = j*NSLOT + k;
            n = nbr_mem[a];
            w = wgt_mem[a];
            p1n = p1_mem[n];
            p2n = p2_mem[n];
            tot += w * (p1n*p1j + p2n*p2j);
            mnr += w * p1n;
         end
         num = (s << 15) + mnr;
         den = ((s << 30) + tot) >> 15;
         if (den == 0) begin
            hf[j] = 1;
            rs[j] = RATIO_UNITY;
            zero_seen = 1;
         end else begin
            rat = (num << 16) / den;
            if (rat > 64'hFFFF_FFFF) rat = 64'hFFFF_FFFF;
            hf[j] = 0;
            rs[j] = rat[31:0];
         end
      end
      for (int j = 0; j < count; j++) begin
         if (!hf[j]) begin
            p = (longint'(p1_mem[first+j]) * longint'(rs[j])) >> 16;
            if (p > ONE_Q15) p = ONE_Q15;
            p1_mem[first+j] = p[15:0];
            p2_mem[first+j] = ONE_Q15 - p[15:0];
         end
      end
   endtask

   function automatic int clamped_samples();
      return (cfg_samples > NSAMP) ? NSAMP : int'(cfg_samples);
   endfunction

   function automatic int clamped_new();
      int nc;
      nc = (cfg_new > NNEW) ? NNEW : int'(cfg_new);
      if (nc > clamped_samples()) nc = clamped_samples();
      return nc;
   endfunction

   task automatic predict_word(input req_word_t w, output rsp_type r);
      int a, sc, nc;
      bit z;
      r.status = ST_OK;
      r.prob_first = '0;
      r.prob_second = '0;
      a = int'(w.row)*NSLOT + int'(w.slot);
      case (w.op)
         OP_LOAD_PROB: begin
            p1_mem[w.row] = w.va;
            p2_mem[w.row] = w.vb;
            if (!prob_written[w.row]) written_rows.push_back(w.row);
            prob_written[w.row] = 1;
         end
         OP_LOAD_NBR, OP_LOAD_WEIGHT: begin
            if (w.row >= NNEW) r.status = ST_RANGE;
            else if (w.op == OP_LOAD_WEIGHT) begin
               wgt_mem[a] = w.va;
               wgt_written[a] = 1;
            end else if (w.va == 0 || w.va > NSAMP) r.status = ST_RANGE;
            else begin
               nbr_mem[a] = w.va - 1;
               nbr_written[a] = 1;
            end
         end
         OP_RUN: begin
            sc = clamped_samples();
            nc = clamped_new();
            for (int i = 0; i < cfg_iter; i++) begin
               replicate_once(sc - nc, nc, z);
               if (z) r.status = ST_ZERO_DEN;
            end
            runs_sent++;
            if (r.status == ST_ZERO_DEN) zero_den_runs++;
         end
         OP_READ: begin
            r.prob_first = p1_mem[w.row];
            r.prob_second = p2_mem[w.row];
         end
         default: ;
      endcase
   endtask

   task automatic send(input logic [2:0] op, input logic [9:0] row, input logic [2:0] slot,
                       input logic [15:0] va, input logic [15:0] vb);
      req_word_t w;
      rsp_type r;
      w.op = op;
      w.row = row;
      w.slot = slot;
      w.va = va;
      w.vb = vb;
      predict_word(w, r);
      pending_words.push_back(w);
      expected_rows.push_back(r);
   endtask

   task automatic write_reg(input csr_type idx, input logic [15:0] d);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      case (idx)
         CSR_SMOOTHING: cfg_smooth = d;
         CSR_ITER:      cfg_iter = d;
         CSR_SAMPLES:   cfg_samples = d[10:0];
         default:       cfg_new = d[8:0];
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] s, input logic [15:0] it,
                             input logic [15:0] sc, input logic [15:0] nc);
      write_reg(CSR_SMOOTHING, s);
      write_reg(CSR_ITER, it);
      write_reg(CSR_SAMPLES, sc);
      write_reg(CSR_NEW, nc);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_rows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_random_row(input int row);
      logic [15:0] p;
      if ($urandom_range(0, 3) != 0) begin
         p = $urandom_range(0, 32768);
         send(OP_LOAD_PROB, row, 0, p, ONE_Q15 - p);
      end else send(OP_LOAD_PROB, row, 0, $urandom, $urandom);
   endtask

   // make every row and table entry the run touches defined, then run
   task automatic run_prepared();
      int first, nc, a;
      nc = clamped_new();
      first = clamped_samples() - nc;
      for (int j = 0; j < nc; j++) begin
         if (!prob_written[first+j]) load_random_row(first+j);
         for (int k = 0; k < NSLOT; k++) begin
            a = j*NSLOT + k;
            if (!nbr_written[a])
               send(OP_LOAD_NBR, j, k,
                    written_rows[$urandom_range(0, written_rows.size()-1)] + 1, $urandom);
            if (!wgt_written[a]) send(OP_LOAD_WEIGHT, j, k, $urandom_range(0, 8192), $urandom);
            if (!prob_written[nbr_mem[a]]) load_random_row(nbr_mem[a]);
         end
      end
      send(OP_RUN, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic random_words(input int count);
      int pick, nc;
      logic [9:0] row;
      logic [15:0] va;
      nc = clamped_new();
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         row = ($urandom_range(0, 6) != 0 && nc > 0) ? $urandom_range(0, nc-1) : $urandom;
         if (pick < 28) load_random_row($urandom_range(0, 2) == 0 ?
                                        $urandom : clamped_samples() - 1 - $urandom_range(0, 20));
         else if (pick < 48) begin
            case ($urandom_range(0, 9))
               0: va = 0;
               1: va = $urandom;
               default: va = $urandom_range(1, NSAMP);
            endcase
            send(OP_LOAD_NBR, row, $urandom, va, $urandom);
         end else if (pick < 66) send(OP_LOAD_WEIGHT, row, $urandom, $urandom, $urandom);
         else if (pick < 90)
            send(OP_READ, written_rows[$urandom_range(0, written_rows.size()-1)],
                 $urandom, $urandom, $urandom);
         else if (pick < 96) run_prepared();
         else send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic run_phase(input logic [15:0] s, input logic [15:0] it, input logic [15:0] sc,
                            input logic [15:0] nc, input int count, input bit long_stall);
      set_config(s, it, sc, nc);
      random_words(count/2);
      if (long_stall) hold_asked++;
      drain();
      random_words(count - count/2);
      drain();
   endtask

   // driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) req_valid <= 1'b0;
      else if (req_valid && !req_taken) ;
      else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         drive_word = pending_words.pop_front();
         req_valid <= 1'b1;
         req_op <= drive_word.op;
         req_row <= drive_word.row;
         req_slot <= drive_word.slot;
         req_value_a <= drive_word.va;
         req_value_b <= drive_word.vb;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else req_valid <= 1'b0;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (reset) rsp_stall <= 1'b0;
      else if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (hold_asked != hold_served) begin
         hold_served++;
         long_hold = 400;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= stall_tick[0];
         endcase
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) words_in++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rows.size() == 0)
               note_mismatch($sformatf("result word with nothing expected, status %0d",
                                       rsp_status));
            else begin
               head = expected_rows.pop_front();
               if (rsp_status !== head.status)
                  note_mismatch($sformatf("status %0d, expected %0d", rsp_status, head.status));
               if (rsp_prob_first !== head.prob_first)
                  note_mismatch($sformatf("prob_first %h, expected %h",
                                          rsp_prob_first, head.prob_first));
               if (rsp_prob_second !== head.prob_second)
                  note_mismatch($sformatf("prob_second %h, expected %h",
                                          rsp_prob_second, head.prob_second));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", expected_rows.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_config(0, 1, 4, 1);
      send(OP_LOAD_PROB, 0, 0, 16'd0, ONE_Q15);
      send(OP_LOAD_PROB, 1, 0, ONE_Q15, 16'd0);
      send(OP_LOAD_PROB, 1023, 7, 16'hFFFF, 16'hFFFF);
      send(OP_LOAD_PROB, 3, 0, 16'h4000, 16'h4000);
      send(OP_READ, 1023, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0);
      for (int k = 0; k < NSLOT; k++) begin
         send(OP_LOAD_NBR, 0, k, (k == 2) ? 16'd1024 : (k % 2) + 1, 0);
         send(OP_LOAD_WEIGHT, 0, k, 16'd0, 0);
      end
      send(OP_RUN, 0, 0, 0, 0);
      send(OP_LOAD_NBR, 0, 1, 16'd0, 0);
      send(OP_LOAD_NBR, 0, 1, 16'd1025, 0);
      send(OP_LOAD_WEIGHT, 256, 0, 16'hFFFF, 0);
      send(3'd5, 1023, 7, 16'hFFFF, 16'hFFFF);
      send(3'd7, 0, 0, 0, 0);
      send(OP_READ, 3, 0, 0, 0);
      drain();

      run_phase(16'd4096, 2, 64, 4, 210, 1);
      run_phase(16'd0, 1, 1024, 2, 175, 0);
      run_phase(16'hFFFF, 3, 300, 8, 175, 1);
      run_phase(16'd100, 4, 40, 16, 175, 0);
      run_phase(16'd1, 2, 1, 256, 70, 0);
      run_phase(16'd300, 0, 20, 3, 70, 0);

      set_config(16'd7, 16'hFFFF, 1024, 0);
      send(OP_RUN, 0, 0, 0, 0);
      send(OP_READ, 1023, 0, 0, 0);
      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d words in, %0d results, %0d runs (%0d with zero denominator)",
               words_in, results_seen, runs_sent, zero_den_runs);
      $display("Config swept smoothing 0..65535, iterations 0..65535, samples 1..1024, new 0..256");
      if (err_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== knn_replicator_dynamics_top.f =====
sv/knn_rd_pkg.sv
sv/knn_rd_div.sv
sv/knn_rd_core.sv
sv/knn_replicator_dynamics_top.sv
sv/knn_rd_checker.sv
verif/knn_replicator_dynamics_top_tb.sv
